FILE: hw/rtl/bpc_pkg.sv
// Shared types and constants of the barometric pressure compensation core.
package bpc_pkg;

	typedef logic [31:0] word_t;

	typedef enum logic [1:0] {
		CFG_AC1_AC2_AC3 = 2'd0,
		CFG_AC4_AC5_AC6 = 2'd1,
		CFG_B1_B2       = 2'd2,
		CFG_MC_MD       = 2'd3
	} cfg_idx_t;

	localparam int unsigned DIV_STEPS = 32;

	localparam word_t B6_OFS   = 32'd4000;
	localparam word_t X3_OFS   = 32'd32768;
	localparam word_t B7_GAIN  = 32'(50000 >> 3);
	localparam word_t PC_X1_K  = 32'd3038;
	localparam word_t PC_X2_K  = 32'hFFFF_E343;
	localparam word_t PC_OFS   = 32'd3791;
	localparam word_t P_MAX    = 32'd262143;
	localparam word_t SIGN_BIT = 32'h8000_0000;

	function automatic word_t asr(input word_t v, input int unsigned s);
		asr = word_t'($signed(v) >>> s);
	endfunction

	function automatic word_t sext16(input logic [15:0] w);
		sext16 = {{16{w[15]}}, w};
	endfunction

endpackage

FILE: hw/rtl/barometric_pressure_compensation_core.sv
// Top level: pipelined temperature and pressure compensation with two bit-serial dividers.
//
// Accepts one raw temperature/pressure pair every clock while the pipeline advances and
// returns one result per item. Each item passes through two 32-stage restoring divider
// pipelines (temperature divisor x1 + md, pressure divisor b4), one quotient bit per stage,
// plus fifteen arithmetic stages holding at most one multiplier level each. The whole
// pipeline advances when the output register is empty or being taken; status is 1 and both
// results are zero when either divisor is zero. Calibration registers are written through
// the cfg channel, which is always ready.
module barometric_pressure_compensation_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [15:0] raw_temperature,
	input  logic [18:0] raw_pressure,
	output logic        result_valid,
	input  logic        result_ready,
	output logic signed [15:0] temperature_tenths,
	output logic [17:0] pressure_pa,
	output logic        status
);

	localparam int unsigned N = bpc_pkg::DIV_STEPS;

	logic [47:0] cal_a_q, cal_b_q;
	logic [31:0] cal_c_q, cal_d_q;
	bpc_pkg::word_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			cal_d_q <= '0;
		end else if (cfg_valid) begin
			case (bpc_pkg::cfg_idx_t'(cfg_index))
				bpc_pkg::CFG_AC1_AC2_AC3: cal_a_q <= cfg_data;
				bpc_pkg::CFG_AC4_AC5_AC6: cal_b_q <= cfg_data;
				bpc_pkg::CFG_B1_B2:       cal_c_q <= cfg_data[31:0];
				bpc_pkg::CFG_MC_MD:       cal_d_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign ac1 = bpc_pkg::sext16(cal_a_q[47:32]);
	assign ac2 = bpc_pkg::sext16(cal_a_q[31:16]);
	assign ac3 = bpc_pkg::sext16(cal_a_q[15:0]);
	assign ac4 = {16'd0, cal_b_q[47:32]};
	assign ac5 = {16'd0, cal_b_q[31:16]};
	assign ac6 = {16'd0, cal_b_q[15:0]};
	assign b1  = bpc_pkg::sext16(cal_c_q[31:16]);
	assign b2  = bpc_pkg::sext16(cal_c_q[15:0]);
	assign mc  = bpc_pkg::sext16(cal_d_q[31:16]);
	assign md  = bpc_pkg::sext16(cal_d_q[15:0]);

	logic adv;
	assign adv        = !result_valid || result_ready;
	assign item_ready = adv;

	// front stages
	logic vld_s1, vld_s2;
	bpc_pkg::word_t d_s1, m_s2;
	logic [18:0] up_s1, up_s2;

	// temperature divider
	logic           a_vld [0:N];
	bpc_pkg::word_t a_rem [0:N];
	bpc_pkg::word_t a_num [0:N];
	bpc_pkg::word_t a_den [0:N];
	bpc_pkg::word_t a_x1  [0:N];
	logic [18:0]    a_up  [0:N];
	logic           a_neg [0:N];
	logic           a_err [0:N];

	// pressure divider
	logic           b_vld  [0:N];
	bpc_pkg::word_t b_rem  [0:N];
	bpc_pkg::word_t b_num  [0:N];
	bpc_pkg::word_t b_den  [0:N];
	logic [15:0]    b_t    [0:N];
	logic           b_post [0:N];
	logic           b_err  [0:N];

	bpc_pkg::word_t x1_t, dv_t, num_t;
	assign x1_t  = bpc_pkg::asr(m_s2, 15);
	assign dv_t  = x1_t + md;
	assign num_t = mc << 11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			a_vld[0] <= 1'b0;
		end else if (adv) begin
			vld_s1   <= item_valid;
			vld_s2   <= vld_s1;
			a_vld[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1     <= {16'd0, raw_temperature} - ac6;
			up_s1    <= raw_pressure;
			m_s2     <= d_s1 * ac5;
			up_s2    <= up_s1;
			a_rem[0] <= '0;
			a_num[0] <= num_t[31] ? (32'd0 - num_t) : num_t;
			a_den[0] <= dv_t[31] ? (32'd0 - dv_t) : dv_t;
			a_neg[0] <= num_t[31] ^ dv_t[31];
			a_err[0] <= (dv_t == '0);
			a_x1[0]  <= x1_t;
			a_up[0]  <= up_s2;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_div
		logic [32:0] a_try, b_try;
		logic        a_ge, b_ge;
		assign a_try = {a_rem[k], a_num[k][31]};
		assign a_ge  = a_try >= {1'b0, a_den[k]};
		assign b_try = {b_rem[k], b_num[k][31]};
		assign b_ge  = b_try >= {1'b0, b_den[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				a_vld[k+1] <= 1'b0;
				b_vld[k+1] <= 1'b0;
			end else if (adv) begin
				a_vld[k+1] <= a_vld[k];
				b_vld[k+1] <= b_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				a_rem[k+1]  <= a_ge ? 32'(a_try - {1'b0, a_den[k]}) : a_try[31:0];
				a_num[k+1]  <= {a_num[k][30:0], a_ge};
				a_den[k+1]  <= a_den[k];
				a_neg[k+1]  <= a_neg[k];
				a_err[k+1]  <= a_err[k];
				a_x1[k+1]   <= a_x1[k];
				a_up[k+1]   <= a_up[k];
				b_rem[k+1]  <= b_ge ? 32'(b_try - {1'b0, b_den[k]}) : b_try[31:0];
				b_num[k+1]  <= {b_num[k][30:0], b_ge};
				b_den[k+1]  <= b_den[k];
				b_t[k+1]    <= b_t[k];
				b_post[k+1] <= b_post[k];
				b_err[k+1]  <= b_err[k];
			end
		end
	end

	// middle stages
	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic err_s4, err_s5, err_s6, err_s7, err_s8, err_s9, err_s10;
	logic [18:0] up_s4, up_s5, up_s6, up_s7, up_s8, up_s9;
	logic [15:0] t_s5, t_s6, t_s7, t_s8, t_s9, t_s10;
	bpc_pkg::word_t b5_s4, b6_s5, sqm_s6, ac2b6_s6, ac3b6_s6;
	bpc_pkg::word_t sq_s7, x2a_s7, x1c_s7, b2sq_s8, b1sq_s8, x2a_s8, x1c_s8;
	bpc_pkg::word_t b3_s9, x3p_s9, b4m_s10, b7_s10;

	bpc_pkg::word_t q_a, x2_t, t_t, x3_t, x3b_t, b4_t;
	logic [15:0] t_sat;
	assign q_a  = a_num[N];
	assign x2_t = a_neg[N] ? (32'd0 - q_a) : q_a;
	assign t_t  = bpc_pkg::asr(b5_s4 + 32'd8, 4);
	assign t_sat = ($signed(t_t) > 32'sd32767)  ? 16'h7FFF :
	               ($signed(t_t) < -32'sd32768) ? 16'h8000 : t_t[15:0];
	assign x3_t  = bpc_pkg::asr(b2sq_s8, 11) + x2a_s8;
	assign x3b_t = bpc_pkg::asr(x1c_s8 + bpc_pkg::asr(b1sq_s8, 16) + 32'd2, 2);
	assign b4_t  = b4m_s10 >> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			vld_s6   <= 1'b0;
			vld_s7   <= 1'b0;
			vld_s8   <= 1'b0;
			vld_s9   <= 1'b0;
			vld_s10  <= 1'b0;
			b_vld[0] <= 1'b0;
		end else if (adv) begin
			vld_s4   <= a_vld[N];
			vld_s5   <= vld_s4;
			vld_s6   <= vld_s5;
			vld_s7   <= vld_s6;
			vld_s8   <= vld_s7;
			vld_s9   <= vld_s8;
			vld_s10  <= vld_s9;
			b_vld[0] <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b5_s4    <= a_x1[N] + x2_t;
			err_s4   <= a_err[N];
			up_s4    <= a_up[N];
			t_s5     <= t_sat;
			b6_s5    <= b5_s4 - bpc_pkg::B6_OFS;
			err_s5   <= err_s4;
			up_s5    <= up_s4;
			sqm_s6   <= b6_s5 * b6_s5;
			ac2b6_s6 <= ac2 * b6_s5;
			ac3b6_s6 <= ac3 * b6_s5;
			t_s6     <= t_s5;
			err_s6   <= err_s5;
			up_s6    <= up_s5;
			sq_s7    <= bpc_pkg::asr(sqm_s6, 12);
			x2a_s7   <= bpc_pkg::asr(ac2b6_s6, 11);
			x1c_s7   <= bpc_pkg::asr(ac3b6_s6, 13);
			t_s7     <= t_s6;
			err_s7   <= err_s6;
			up_s7    <= up_s6;
			b2sq_s8  <= b2 * sq_s7;
			b1sq_s8  <= b1 * sq_s7;
			x2a_s8   <= x2a_s7;
			x1c_s8   <= x1c_s7;
			t_s8     <= t_s7;
			err_s8   <= err_s7;
			up_s8    <= up_s7;
			b3_s9    <= bpc_pkg::asr((((ac1 << 2) + x3_t) << 3) + 32'd2, 2);
			x3p_s9   <= x3b_t + bpc_pkg::X3_OFS;
			t_s9     <= t_s8;
			err_s9   <= err_s8;
			up_s9    <= up_s8;
			b4m_s10  <= ac4 * x3p_s9;
			b7_s10   <= ({13'd0, up_s9} - b3_s9) * bpc_pkg::B7_GAIN;
			t_s10    <= t_s9;
			err_s10  <= err_s9;
			b_rem[0]  <= '0;
			b_num[0]  <= b7_s10[31] ? b7_s10 : (b7_s10 << 1);
			b_post[0] <= b7_s10[31];
			b_den[0]  <= b4_t;
			b_err[0]  <= err_s10 || (b4_t == '0);
			b_t[0]    <= t_s10;
		end
	end

	// second-order correction and output
	logic vld_s12, vld_s13, vld_s14;
	logic err_s12, err_s13, err_s14;
	logic [15:0] t_s12, t_s13, t_s14;
	bpc_pkg::word_t p_s12, p_s13, p_s14, hh_s13, m7_s13, m3_s14, x2_s14;
	bpc_pkg::word_t h_t, pf_t;

	assign h_t  = bpc_pkg::asr(p_s12, 8);
	assign pf_t = p_s14 + bpc_pkg::asr(bpc_pkg::asr(m3_s14, 16) + x2_s14 + bpc_pkg::PC_OFS, 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12      <= 1'b0;
			vld_s13      <= 1'b0;
			vld_s14      <= 1'b0;
			result_valid <= 1'b0;
		end else if (adv) begin
			vld_s12      <= b_vld[N];
			vld_s13      <= vld_s12;
			vld_s14      <= vld_s13;
			result_valid <= vld_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s12   <= b_post[N] ? (b_num[N] << 1) : b_num[N];
			err_s12 <= b_err[N];
			t_s12   <= b_t[N];
			hh_s13  <= h_t * h_t;
			m7_s13  <= bpc_pkg::PC_X2_K * p_s12;
			p_s13   <= p_s12;
			err_s13 <= err_s12;
			t_s13   <= t_s12;
			m3_s14  <= hh_s13 * bpc_pkg::PC_X1_K;
			x2_s14  <= bpc_pkg::asr(m7_s13, 16);
			p_s14   <= p_s13;
			err_s14 <= err_s13;
			t_s14   <= t_s13;
			status  <= err_s14;
			if (err_s14) begin
				temperature_tenths <= '0;
				pressure_pa        <= '0;
			end else begin
				temperature_tenths <= t_s14;
				if (pf_t[31])
					pressure_pa <= '0;
				else if (pf_t > bpc_pkg::P_MAX)
					pressure_pa <= bpc_pkg::P_MAX[17:0];
				else
					pressure_pa <= pf_t[17:0];
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> temperature_tenths == '0 && pressure_pa == '0)
		else $error("error result carries nonzero fields");

	a_div_t_rem: assert property (@(posedge clk) disable iff (!arst_n)
		a_vld[N] && !a_err[N] |-> a_rem[N] < a_den[N])
		else $error("temperature divider remainder not below divisor");

	a_div_p_rem: assert property (@(posedge clk) disable iff (!arst_n)
		b_vld[N] && !b_err[N] |-> b_rem[N] < b_den[N])
		else $error("pressure divider remainder not below divisor");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(pressure_pa))
		else $error("output changed while stalled");
`endif

endmodule
